// File: design/cfir_pkg.sv
// Shared types and constants for the complex FIR filter.
// No dependencies; compile first.
package cfir_pkg;

	localparam int TAP_W      = 16;
	localparam int FRAC_BITS  = 15;
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 6;
	localparam int CFG_W      = 7;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CFG_W-1:0] TAP_COUNT_RST = 7'd64;
	localparam logic [0:0]       REG_TAP_COUNT = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_WR_TAP = 2'd1,
		OP_WR_DLY = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic shift;
		logic rotate;
		logic wr_tap;
		logic wr_dly;
	} cell_ctrl_t;

endpackage

// File: design/cfir_ifs.sv
// Valid/ready channel interfaces for the complex FIR filter input and result.
// Depends on cfir_pkg.
interface cfir_in_if #(parameter int VAL_W = 16);
	import cfir_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [SLOT_W-1:0]        slot_index;
	logic signed [VAL_W-1:0]  value_re;
	logic signed [VAL_W-1:0]  value_im;
	modport source(output valid, operation, slot_index, value_re, value_im, input ready);
	modport sink(input valid, operation, slot_index, value_re, value_im, output ready);
endinterface

interface cfir_out_if #(parameter int OUT_W = 16);
	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  out_re;
	logic signed [OUT_W-1:0]  out_im;
	logic                     saturated;
	modport source(output valid, out_re, out_im, saturated, input ready);
	modport sink(input valid, out_re, out_im, saturated, output ready);
endinterface

// File: design/cfir_cell.sv
// One cell of the filter chain: a delay-line entry and a tap.
// Shifts, rotates with its neighbor, or takes a write. Depends on cfir_pkg.
module cfir_cell #(
	parameter int IDX          = 0,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfir_pkg::cell_ctrl_t                  ctrl,
	input  logic [cfir_pkg::SLOT_W-1:0]           slot,
	input  logic signed [SAMPLE_WIDTH-1:0]        wr_dly_re,
	input  logic signed [SAMPLE_WIDTH-1:0]        wr_dly_im,
	input  logic signed [cfir_pkg::TAP_W-1:0]     wr_tap_re,
	input  logic signed [cfir_pkg::TAP_W-1:0]     wr_tap_im,
	input  logic signed [SAMPLE_WIDTH-1:0]        shift_re,
	input  logic signed [SAMPLE_WIDTH-1:0]        shift_im,
	input  logic signed [SAMPLE_WIDTH-1:0]        rot_dly_re,
	input  logic signed [SAMPLE_WIDTH-1:0]        rot_dly_im,
	input  logic signed [cfir_pkg::TAP_W-1:0]     rot_tap_re,
	input  logic signed [cfir_pkg::TAP_W-1:0]     rot_tap_im,
	output logic signed [SAMPLE_WIDTH-1:0]        dly_re,
	output logic signed [SAMPLE_WIDTH-1:0]        dly_im,
	output logic signed [cfir_pkg::TAP_W-1:0]     tap_re,
	output logic signed [cfir_pkg::TAP_W-1:0]     tap_im
);
	import cfir_pkg::*;

	logic                           hit;
	logic signed [SAMPLE_WIDTH-1:0] dly_re_q, dly_im_q;
	logic signed [TAP_W-1:0]        tap_re_q, tap_im_q;

	assign hit = (32'(slot) == IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_re_q <= '0;
			dly_im_q <= '0;
		end else if (ctrl.rotate) begin
			dly_re_q <= rot_dly_re;
			dly_im_q <= rot_dly_im;
		end else if (ctrl.shift) begin
			dly_re_q <= shift_re;
			dly_im_q <= shift_im;
		end else if (ctrl.wr_dly && hit) begin
			dly_re_q <= wr_dly_re;
			dly_im_q <= wr_dly_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_re_q <= '0;
			tap_im_q <= '0;
		end else if (ctrl.rotate) begin
			tap_re_q <= rot_tap_re;
			tap_im_q <= rot_tap_im;
		end else if (ctrl.wr_tap && hit) begin
			tap_re_q <= wr_tap_re;
			tap_im_q <= wr_tap_im;
		end
	end

	assign dly_re = dly_re_q;
	assign dly_im = dly_im_q;
	assign tap_re = tap_re_q;
	assign tap_im = tap_im_q;

endmodule

// File: design/cfir_mac.sv
// Complex multiply-accumulate at the head of the cell chain, with rounding
// and saturation of the final sum. Depends on cfir_pkg.
module cfir_mac #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CNT_W        = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic                              en,
	input  logic signed [SAMPLE_WIDTH-1:0]    dly_re,
	input  logic signed [SAMPLE_WIDTH-1:0]    dly_im,
	input  logic signed [cfir_pkg::TAP_W-1:0] tap_re,
	input  logic signed [cfir_pkg::TAP_W-1:0] tap_im,
	output logic signed [SAMPLE_WIDTH-1:0]    res_re,
	output logic signed [SAMPLE_WIDTH-1:0]    res_im,
	output logic                              sat
);
	import cfir_pkg::*;

	localparam int PW    = SAMPLE_WIDTH + TAP_W;
	localparam int ACC_W = PW + CNT_W + 2;
	localparam int RW    = ACC_W + 1 - FRAC_BITS;
	localparam logic signed [ACC_W:0] HALF =
		{{(ACC_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

	logic                    en_s1;
	logic signed [PW-1:0]    p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [PW:0]      sum_re, sum_im;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [ACC_W:0]   rnd_re, rnd_im;
	logic signed [RW-1:0]    r_re, r_im;
	logic [SAMPLE_WIDTH:0]   sat_re, sat_im;

	function automatic logic [SAMPLE_WIDTH:0] clip(input logic signed [RW-1:0] r);
		logic [RW-SAMPLE_WIDTH:0] top;
		logic                     over;
		top  = r[RW-1:SAMPLE_WIDTH-1];
		over = !((&top) || !(|top));
		if (over) begin
			clip = r[RW-1] ? {1'b1, 1'b1, {(SAMPLE_WIDTH - 1){1'b0}}}
			               : {1'b1, 1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
		end else begin
			clip = {1'b0, r[SAMPLE_WIDTH-1:0]};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= en;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= PW'(tap_re) * PW'(dly_re);
		p_ii_s1 <= PW'(tap_im) * PW'(dly_im);
		p_ri_s1 <= PW'(tap_re) * PW'(dly_im);
		p_ir_s1 <= PW'(tap_im) * PW'(dly_re);
	end

	assign sum_re = (PW + 1)'(p_rr_s1) - (PW + 1)'(p_ii_s1);
	assign sum_im = (PW + 1)'(p_ri_s1) + (PW + 1)'(p_ir_s1);

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (en_s1) begin
			acc_re_q <= acc_re_q + ACC_W'(sum_re);
			acc_im_q <= acc_im_q + ACC_W'(sum_im);
		end
	end

	assign rnd_re = (ACC_W + 1)'(acc_re_q) + HALF;
	assign rnd_im = (ACC_W + 1)'(acc_im_q) + HALF;
	assign r_re   = rnd_re[ACC_W:FRAC_BITS];
	assign r_im   = rnd_im[ACC_W:FRAC_BITS];
	assign sat_re = clip(r_re);
	assign sat_im = clip(r_im);

	assign res_re = sat_re[SAMPLE_WIDTH-1:0];
	assign res_im = sat_im[SAMPLE_WIDTH-1:0];
	assign sat    = sat_re[SAMPLE_WIDTH] | sat_im[SAMPLE_WIDTH];

endmodule

// File: design/complex_fir_filter.sv
// Top level of the complex FIR filter: cell chain, sequencer, config port.
// Depends on cfir_pkg, cfir_in_if, cfir_out_if, cfir_cell and cfir_mac.
//
// Complex FIR, y[n] = sum of tap[k]*x[n-k] over tap_count taps (0 acts as 1,
// values above MAX_TAPS act as MAX_TAPS), with Q1.15 taps, half-up rounding
// and saturation to SAMPLE_WIDTH bits. Tap writes and delay-line presets are
// taken only while idle. A sample push keeps the block busy: the row of
// MAX_TAPS cells rotates once past the single complex multiply-accumulate
// unit at its head, one cell per cycle, and the sum then passes a product
// register, the accumulator and the rounding stage. A finished result waits
// in the output register while new items are taken; the next result is held
// back only if that register is still full.
module complex_fir_filter #(
	parameter int MAX_TAPS     = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cfir_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [cfir_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [cfir_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	cfir_in_if.sink                              in_ch,
	cfir_out_if.source                           out_ch
);
	import cfir_pkg::*;

	localparam int CNT_W = $clog2(MAX_TAPS);
	localparam int CMP_W = CNT_W + CFG_W;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_TAPS - 1);

	state_t                         state_q, state_d;
	logic [CNT_W-1:0]               cnt_q, cnt_d;
	logic [CFG_W-1:0]               tap_count_q;
	cell_ctrl_t                     ctrl;
	logic                           in_ready, accept, push, use_tap, mac_en, load_out;
	logic                           cfg_wr;

	logic signed [SAMPLE_WIDTH-1:0] dly_re [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] dly_im [MAX_TAPS];
	logic signed [TAP_W-1:0]        tap_re [MAX_TAPS];
	logic signed [TAP_W-1:0]        tap_im [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] smp_re, smp_im;
	logic signed [TAP_W-1:0]        new_tap_re, new_tap_im;

	logic signed [SAMPLE_WIDTH-1:0] res_re, res_im;
	logic                           res_sat;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_re_q, out_im_q;
	logic                           out_sat_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
	                (paddr[APB_ADDR_W-1:2] == REG_TAP_COUNT);
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_TAP_COUNT) ?
	                APB_DATA_W'(tap_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RST;
		end else if (cfg_wr) begin
			tap_count_q <= pwdata[CFG_W-1:0];
		end
	end

	// input decode
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_ch.valid && in_ready;
	assign push       = accept && (op_t'(in_ch.operation) == OP_PUSH);
	assign smp_re     = in_ch.value_re[SAMPLE_WIDTH-1:0];
	assign smp_im     = in_ch.value_im[SAMPLE_WIDTH-1:0];
	assign new_tap_re = in_ch.value_re[TAP_W-1:0];
	assign new_tap_im = in_ch.value_im[TAP_W-1:0];
	assign use_tap    = (CMP_W'(cnt_q) < CMP_W'(tap_count_q)) || (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		mac_en      = 1'b0;
		load_out    = 1'b0;
		ctrl        = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.shift  = push;
				ctrl.wr_tap = accept && (op_t'(in_ch.operation) == OP_WR_TAP);
				ctrl.wr_dly = accept && (op_t'(in_ch.operation) == OP_WR_DLY);
				if (push) begin
					state_d = ST_RUN;
					cnt_d   = '0;
				end
			end
			ST_RUN: begin
				ctrl.rotate = 1'b1;
				mac_en      = use_tap;
				if (cnt_q == LAST_CNT) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	assign in_ch.ready = in_ready;

	// cell chain
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		localparam int NXT = (k + 1) % MAX_TAPS;
		logic signed [SAMPLE_WIDTH-1:0] sh_re, sh_im;
		if (k == 0) begin : g_head
			assign sh_re = smp_re;
			assign sh_im = smp_im;
		end else begin : g_body
			assign sh_re = dly_re[k-1];
			assign sh_im = dly_im[k-1];
		end
		cfir_cell #(
			.IDX          (k),
			.SAMPLE_WIDTH (SAMPLE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.slot       (in_ch.slot_index),
			.wr_dly_re  (smp_re),
			.wr_dly_im  (smp_im),
			.wr_tap_re  (new_tap_re),
			.wr_tap_im  (new_tap_im),
			.shift_re   (sh_re),
			.shift_im   (sh_im),
			.rot_dly_re (dly_re[NXT]),
			.rot_dly_im (dly_im[NXT]),
			.rot_tap_re (tap_re[NXT]),
			.rot_tap_im (tap_im[NXT]),
			.dly_re     (dly_re[k]),
			.dly_im     (dly_im[k]),
			.tap_re     (tap_re[k]),
			.tap_im     (tap_im[k])
		);
	end

	cfir_mac #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.CNT_W        (CNT_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (push),
		.en     (mac_en),
		.dly_re (dly_re[0]),
		.dly_im (dly_im[0]),
		.tap_re (tap_re[0]),
		.tap_im (tap_im[0]),
		.res_re (res_re),
		.res_im (res_im),
		.sat    (res_sat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_re_q  <= res_re;
			out_im_q  <= res_im;
			out_sat_q <= res_sat;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_re    = out_re_q;
	assign out_ch.out_im    = out_im_q;
	assign out_ch.saturated = out_sat_q;

`ifndef SYNTHESIS
	a_push_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("push did not start the chain rotation");

	a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> (cnt_q == '0))
		else $error("step counter nonzero outside rotation");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && (!out_valid_q || out_ch.ready)
		|=> out_ch.valid && in_ch.ready)
		else $error("finished result not presented");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) || (state_q == ST_DRAIN) |-> !in_ch.ready)
		else $error("input taken during accumulation");
`endif

endmodule
